[hdl/e2q_pkg.sv]
`timescale 1ns / 1ps
package e2q_pkg;

  localparam int unsigned AngleW     = 18;
  localparam int unsigned QuatW      = 16;
  localparam int unsigned CordicW    = 34;
  localparam int unsigned Q20W       = 22;
  localparam int unsigned DefSteps   = 16;
  localparam int          HalfPeriod = 184320;
  localparam int          HalfHalf   = 92160;
  localparam int          Quarter    = 46080;
  localparam longint      RadScale   = 64'd2398762258;
  localparam longint      CordicGain = 64'd652032874;
  localparam int          Q14One     = 16384;

  typedef logic signed [AngleW-1:0]  angle_t;
  typedef logic signed [QuatW-1:0]   quat_t;
  typedef logic signed [CordicW-1:0] cval_t;
  typedef logic signed [Q20W-1:0]    q20_t;

  // one CORDIC cell's working set for the three angles
  typedef struct packed {
    cval_t [2:0] x;
    cval_t [2:0] y;
    cval_t [2:0] z;
    logic  [2:0] flip;
  } cell_t;

  function automatic cval_t atan_q30(input int unsigned i);
    cval_t r;
    case (i)
      0: r = 34'sh03243F6A8;
      1: r = 34'sh01DAC6705;
      2: r = 34'sh00FADBAFC;
      3: r = 34'sh007F56EA6;
      4: r = 34'sh003FEAB76;
      5: r = 34'sh001FFD55B;
      6: r = 34'sh000FFFAAA;
      7: r = 34'sh0007FFF55;
      8: r = 34'sh0003FFFEA;
      9: r = 34'sh0001FFFFD;
      default: begin
        if (i <= 30) r = cval_t'((64'sd1 <<< (30 - i)) - 64'sd1);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

[hdl/e2q_if.sv]
`timescale 1ns / 1ps
interface e2q_in_if;
  import e2q_pkg::*;
  logic   valid;
  logic   ready;
  angle_t angle_x;
  angle_t angle_y;
  angle_t angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2q_out_if;
  import e2q_pkg::*;
  logic  valid;
  logic  ready;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;
  quat_t quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

[hdl/euler_to_quaternion.sv]
`timescale 1ns / 1ps
// Euler angles (1/256 degree, Y-X-Z order) to a unit quaternion in Q2.14.
// Fully pipelined: one transfer per cycle while the output is not stalled, through
// the prep stages, a chain of CORDIC cells (one per iteration) and the multiplier
// stages. The whole pipe stalls while the output register holds an untaken
// result.
module euler_to_quaternion #(
  parameter int unsigned CORDIC_STEPS = e2q_pkg::DefSteps
) (
  input  logic clk_i,
  input  logic rst_ni,
  e2q_in_if.sink    in_i,
  e2q_out_if.source out_o
);
  import e2q_pkg::*;

  logic   en;
  angle_t ang [3];
  logic   v_c [CORDIC_STEPS+1];
  cell_t  d_c [CORDIC_STEPS+1];
  quat_t  q   [4];

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign ang[0] = in_i.angle_x;
  assign ang[1] = in_i.angle_y;
  assign ang[2] = in_i.angle_z;

  e2q_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .angle_i(ang),
    .valid_o(v_c[0]), .data_o(d_c[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    e2q_cell #(.Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(v_c[g]), .data_i(d_c[g]),
      .valid_o(v_c[g+1]), .data_o(d_c[g+1])
    );
  end

  e2q_combine u_comb (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_c[CORDIC_STEPS]),
    .data_i(d_c[CORDIC_STEPS]), .valid_o(out_o.valid), .quat_o(q)
  );

  assign out_o.quat_x = q[0];
  assign out_o.quat_y = q[1];
  assign out_o.quat_z = q[2];
  assign out_o.quat_w = q[3];

`ifndef SYNTH
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready) else $error("pipe stalled with no result");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.quat_w <= 16'sd16384 && out_o.quat_w >= -16'sd16384))
    else $error("w out of range");
`endif
endmodule

[hdl/e2q_cell.sv]
`timescale 1ns / 1ps
module e2q_cell #(
  parameter int unsigned Step = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  e2q_pkg::cell_t  data_i,
  output logic            valid_o,
  output e2q_pkg::cell_t  data_o
);
  import e2q_pkg::*;

  cell_t data_d, data_q;
  logic  valid_q;

  always_comb begin
    data_d = data_i;
    for (int k = 0; k < 3; k++) begin
      if (!data_i.z[k][CordicW-1]) begin
        data_d.x[k] = data_i.x[k] - (data_i.y[k] >>> Step);
        data_d.y[k] = data_i.y[k] + (data_i.x[k] >>> Step);
        data_d.z[k] = data_i.z[k] - atan_q30(Step);
      end else begin
        data_d.x[k] = data_i.x[k] + (data_i.y[k] >>> Step);
        data_d.y[k] = data_i.y[k] - (data_i.x[k] >>> Step);
        data_d.z[k] = data_i.z[k] + atan_q30(Step);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

[hdl/e2q_prep.sv]
`timescale 1ns / 1ps
module e2q_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  e2q_pkg::angle_t angle_i [3],
  output logic            valid_o,
  output e2q_pkg::cell_t  data_o
);
  import e2q_pkg::*;

  // stage 1: range reduction, stage 2: scale to q30 radians
  logic        valid1_q, valid2_q;
  logic [16:0] mag_q [3];
  logic [2:0]  neg_q, flip_q, neg2_q, flip2_q;
  logic [16:0] mag_d [3];
  logic [2:0]  neg_d, flip_d;
  logic [30:0] rad_q [3];
  cell_t       out;

  always_comb begin
    logic signed [19:0] h;
    for (int k = 0; k < 3; k++) begin
      h = 20'(angle_i[k]);
      if (h < 0) h = h + 20'(HalfPeriod);
      if (h >= 20'(HalfHalf)) h = h - 20'(HalfPeriod);
      flip_d[k] = 1'b0;
      if (h > 20'(Quarter)) begin
        h = 20'(HalfHalf) - h;
        flip_d[k] = 1'b1;
      end else if (h < -20'(Quarter)) begin
        h = -20'(HalfHalf) - h;
        flip_d[k] = 1'b1;
      end
      neg_d[k] = h[19];
      mag_d[k] = h[19] ? 17'(-h) : 17'(h);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      flip_q  <= flip_d;
      neg2_q  <= neg_q;
      flip2_q <= flip_q;
      for (int k = 0; k < 3; k++) begin
        rad_q[k] <= 31'((49'(mag_q[k]) * 49'(RadScale)) >> 16);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out.x[k] = cval_t'(CordicGain);
      out.y[k] = '0;
      out.z[k] = neg2_q[k] ? -cval_t'(rad_q[k]) : cval_t'(rad_q[k]);
    end
    out.flip = flip2_q;
  end

  assign valid_o = valid2_q;
  assign data_o  = out;
endmodule

[hdl/e2q_combine.sv]
`timescale 1ns / 1ps
module e2q_combine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  e2q_pkg::cell_t  data_i,
  output logic            valid_o,
  output e2q_pkg::quat_t  quat_o [4]
);
  import e2q_pkg::*;

  // index: 0 = x, 1 = y, 2 = z angle
  q20_t s_q [3], c_q [3];
  logic signed [43:0] p_q [8];
  q20_t ab_q [8], cc_q [8], cc2_q [8];
  logic signed [43:0] t_q [8];
  quat_t q_q [4];
  logic [4:0] v_q;
  q20_t a_s [8], b_s [8], c_s [8];

  function automatic q20_t rnd10(input cval_t v);
    cval_t t;
    t = v + cval_t'(512);
    return q20_t'(t >>> 10);
  endfunction

  function automatic quat_t to_q14(input logic signed [43:0] a,
                                   input logic signed [43:0] b, input logic sub);
    logic signed [45:0] s;
    logic signed [19:0] r;
    s = sub ? 46'(a) - 46'(b) : 46'(a) + 46'(b);
    s = s + (46'sd1 <<< 25);
    r = 20'(s >>> 26);
    if (r > 20'(Q14One)) r = 20'(Q14One);
    if (r < -20'(Q14One)) r = -20'(Q14One);
    return quat_t'(r);
  endfunction

  always_comb begin
    // products in order: x, y, z, w pairs
    a_s[0] = c_q[1]; b_s[0] = s_q[0]; c_s[0] = c_q[2];
    a_s[1] = s_q[1]; b_s[1] = c_q[0]; c_s[1] = s_q[2];
    a_s[2] = s_q[1]; b_s[2] = c_q[0]; c_s[2] = c_q[2];
    a_s[3] = c_q[1]; b_s[3] = s_q[0]; c_s[3] = s_q[2];
    a_s[4] = c_q[1]; b_s[4] = c_q[0]; c_s[4] = s_q[2];
    a_s[5] = s_q[1]; b_s[5] = s_q[0]; c_s[5] = c_q[2];
    a_s[6] = c_q[1]; b_s[6] = c_q[0]; c_s[6] = c_q[2];
    a_s[7] = s_q[1]; b_s[7] = s_q[0]; c_s[7] = s_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[3:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        s_q[k] <= rnd10(data_i.y[k]);
        c_q[k] <= rnd10(data_i.flip[k] ? -data_i.x[k] : data_i.x[k]);
      end
      for (int j = 0; j < 8; j++) begin
        p_q[j]   <= 44'(a_s[j]) * 44'(b_s[j]);
        cc_q[j]  <= c_s[j];
        cc2_q[j] <= cc_q[j];
        ab_q[j]  <= q20_t'((p_q[j] + 44'sd524288) >>> 20);
        t_q[j]   <= 44'(ab_q[j]) * 44'(cc2_q[j]);
      end
      q_q[0] <= to_q14(t_q[0], t_q[1], 1'b0);
      q_q[1] <= to_q14(t_q[2], t_q[3], 1'b1);
      q_q[2] <= to_q14(t_q[4], t_q[5], 1'b1);
      q_q[3] <= to_q14(t_q[6], t_q[7], 1'b0);
    end
  end

  // cc_q must trail one stage to line up with ab_q
  assign valid_o = v_q[4];
  assign quat_o  = q_q;
endmodule
